// ===== hdl/spbar_pkg.sv =====
// ----------------------------------------------------------------------------
// spbar_pkg - shared types and constants for the spectrum bar renderer
// Field widths, word opcodes, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package spbar_pkg;

  // default sizing
  localparam int MAX_BANDS_DEF     = 8;
  localparam int MAX_LEDS_DEF      = 32;
  localparam int LEVEL_MAX_DEF     = 1023;

  // decay interval base in microseconds
  localparam int DECAY_BASE_US     = 250000;

  // word field widths
  localparam int OP_W              = 2;
  localparam int BAND_W            = 3;
  localparam int LEVEL_W           = 10;
  localparam int TIME_W            = 32;
  localparam int PIXEL_W           = 8;
  localparam int COLOR_W           = 24;

  // register widths
  localparam int NB_W              = 4;
  localparam int LPB_W             = 6;
  localparam int SPEED_W           = 8;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 24;

  // elapsed times at or past the base need no multiply; below it they fit here
  localparam int ELAPSED_W         = $clog2(DECAY_BASE_US);
  // multiplier A operand: elapsed + 1, level or LED position
  localparam int MUL_A_W           = ELAPSED_W + 1;

  typedef enum logic [OP_W-1:0] {
    OP_LEVEL = 2'd0,
    OP_TICK  = 2'd1,
    OP_QUERY = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_BANDS  = 3'd0,
    REG_LEDS       = 3'd1,
    REG_SPEED      = 3'd2,
    REG_BAR_COLOR  = 3'd3,
    REG_PEAK_COLOR = 3'd4
  } reg_idx_t;

  localparam logic [NB_W-1:0]    NUM_BANDS_RST  = 4'd7;
  localparam logic [LPB_W-1:0]   LEDS_RST       = 6'd16;
  localparam logic [SPEED_W-1:0] SPEED_RST      = 8'd10;
  localparam logic [COLOR_W-1:0] BAR_COLOR_RST  = 24'h0000FF;
  localparam logic [COLOR_W-1:0] PEAK_COLOR_RST = 24'hFF0000;

endpackage

`default_nettype wire

// ===== hdl/spectrum_bar_peak_hold_render_core.sv =====
// ----------------------------------------------------------------------------
// spectrum_bar_peak_hold_render_core - bar graph with peak hold and decay
// Per-band level and held peak, timed peak decay, per-pixel color lookup.
// ----------------------------------------------------------------------------
// One input word is worked at a time; in_ready is high only while the
// sequencer is idle. A level write uses a write state and a clear needs
// none; a time tick multiplies, compares and, if the decay fires, walks
// the bands in use on the single peak read port. A pixel query runs 8
// restoring divide steps for band and position, three passes through the
// shared multiplier, a compare step and the output load; past the bands
// in use only the load follows the divide, and a zero LED count runs the
// load alone. The result sits in an output register, so a new word is
// taken while a query result still waits for out_ready; a further query
// only stalls at its last step if that result has not yet been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module spectrum_bar_peak_hold_render_core #(
  parameter int MAX_BANDS         = spbar_pkg::MAX_BANDS_DEF,
  parameter int MAX_LEDS_PER_BAND = spbar_pkg::MAX_LEDS_DEF,
  parameter int LEVEL_MAX         = spbar_pkg::LEVEL_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [spbar_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [spbar_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input words
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [spbar_pkg::OP_W-1:0]          op,
  input  logic [spbar_pkg::BAND_W-1:0]        band,
  input  logic [spbar_pkg::LEVEL_W-1:0]       level,
  input  logic [spbar_pkg::TIME_W-1:0]        now_us,
  input  logic [spbar_pkg::PIXEL_W-1:0]       pixel,
  // result words
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [spbar_pkg::COLOR_W-1:0]       color,
  output logic [spbar_pkg::PIXEL_W-1:0]       pixel_out
);
  import spbar_pkg::*;

  localparam int IW = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam int MW = $clog2(LEVEL_MAX + 1);
  localparam int BW = (MW > SPEED_W) ? MW : SPEED_W;
  localparam int PW = MUL_A_W + BW;
  localparam int DIV_STEPS = PIXEL_W;
  localparam int DCW = $clog2(DIV_STEPS);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_LVLWR    = 11'b000_0000_0010,
    S_TICK_MUL = 11'b000_0000_0100,
    S_TICK_CMP = 11'b000_0000_1000,
    S_DECAY    = 11'b000_0001_0000,
    S_DIV      = 11'b000_0010_0000,
    S_MUL_LV   = 11'b000_0100_0000,
    S_MUL_PK   = 11'b000_1000_0000,
    S_MUL_POS  = 11'b001_0000_0000,
    S_DECIDE   = 11'b010_0000_0000,
    S_FINISH   = 11'b100_0000_0000
  } state_t;

  state_t state;

  // configuration registers
  logic [NB_W-1:0]    num_bands;
  logic [LPB_W-1:0]   leds_per_band;
  logic [SPEED_W-1:0] decay_rate;
  logic [COLOR_W-1:0] bar_rgb;
  logic [COLOR_W-1:0] peak_rgb;

  // band state
  logic [LEVEL_W-1:0] levels [MAX_BANDS];
  logic [LEVEL_W-1:0] peaks  [MAX_BANDS];
  logic [TIME_W-1:0]  last_decay_time;

  // working registers
  logic [IW-1:0]      idx;        // single shared read/write index into the band arrays
  logic [LEVEL_W-1:0] lvl;
  logic [TIME_W-1:0]  elapsed;
  logic [TIME_W-1:0]  now_hold;
  logic [PIXEL_W-1:0] pix;
  logic [LPB_W-1:0]   rem;        // divide remainder, ends as position inside the band
  logic [PIXEL_W-1:0] quo;        // dividend shifting out, quotient shifting in
  logic [DCW-1:0]     div_cnt;
  logic [PW-1:0]      prod;
  logic [PW-1:0]      lv_prod;
  logic [PW-1:0]      pk_prod;
  logic [COLOR_W-1:0] color_hold;

  // effective register values after clamping to the build limits (a zero decay rate counts as one)
  logic [NB_W-1:0]    nb;
  logic [LPB_W-1:0]   lpb;
  logic [SPEED_W-1:0] speed;

  assign nb    = (int'(num_bands) > MAX_BANDS) ? NB_W'(MAX_BANDS) : num_bands;
  assign lpb   = (int'(leds_per_band) > MAX_LEDS_PER_BAND) ?
                 LPB_W'(MAX_LEDS_PER_BAND) : leds_per_band;
  assign speed = (decay_rate == '0) ? SPEED_W'(1) : decay_rate;

  assign in_ready = (state == S_IDLE);

  logic accept;
  assign accept = in_valid && in_ready;

  logic out_free;
  assign out_free = !out_valid || out_ready;

  // array read port
  logic [LEVEL_W-1:0] lvl_rd;
  logic [LEVEL_W-1:0] pk_rd;
  assign lvl_rd = levels[idx];
  assign pk_rd  = peaks[idx];

  // level saturated to the configured full scale
  logic [LEVEL_W-1:0] lvl_sat;
  assign lvl_sat = (int'(level) > LEVEL_MAX) ? LEVEL_W'(LEVEL_MAX) : level;

  // --- shared multiplier; operands picked by the sequencer state ---
  logic [MUL_A_W-1:0] mul_a;
  logic [BW-1:0]      mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_TICK_MUL: begin
        mul_a = MUL_A_W'(elapsed[ELAPSED_W-1:0]) + MUL_A_W'(1);
        mul_b = BW'(speed);
      end
      S_MUL_LV: begin
        mul_a = MUL_A_W'(lvl_rd);
        mul_b = BW'(lpb);
      end
      S_MUL_PK: begin
        mul_a = MUL_A_W'(pk_rd);
        mul_b = BW'(lpb);
      end
      S_MUL_POS: begin
        mul_a = MUL_A_W'(rem);
        mul_b = BW'(LEVEL_MAX);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Decay fires when elapsed >= floor(BASE / speed). For integers this is
  // (elapsed + 1) * speed > BASE; large elapsed values fire outright.
  logic decay_fire;
  assign decay_fire = (elapsed >= TIME_W'(DECAY_BASE_US)) ||
                      (prod > PW'(DECAY_BASE_US));

  // --- restoring divide step: pixel / lpb, one quotient bit per cycle ---
  logic [LPB_W:0]     trial;
  logic               trial_ge;
  logic [LPB_W-1:0]   rem_next;
  logic [PIXEL_W-1:0] quo_next;

  assign trial    = {rem, quo[PIXEL_W-1]};
  assign trial_ge = (trial >= {1'b0, lpb});
  assign rem_next = trial_ge ? LPB_W'(trial - {1'b0, lpb}) : LPB_W'(trial);
  assign quo_next = {quo[PIXEL_W-2:0], trial_ge};

  // --- pixel decision ---
  // bar: pos < floor(lv*l/M)   <=> lv*l >= (pos+1)*M
  // peak: pos == min(floor(pk*l/M), l-1)
  //   <=> pk*l >= pos*M and (pos is the last LED or pk*l < (pos+1)*M)
  logic [PW-1:0] pos_m1;
  logic          last_led;
  logic          peak_hit;
  logic          bar_hit;

  assign pos_m1   = prod + PW'(LEVEL_MAX);
  assign last_led = (rem == lpb - LPB_W'(1));
  assign peak_hit = (pk_prod >= prod) && (last_led || (pk_prod < pos_m1));
  assign bar_hit  = (lv_prod >= pos_m1);

  // --- control and band state ---
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      num_bands       <= NUM_BANDS_RST;
      leds_per_band   <= LEDS_RST;
      decay_rate      <= SPEED_RST;
      bar_rgb         <= BAR_COLOR_RST;
      peak_rgb        <= PEAK_COLOR_RST;
      last_decay_time <= '0;
      idx             <= '0;
      div_cnt         <= '0;
      for (int i = 0; i < MAX_BANDS; i++) begin
        levels[i] <= '0;
        peaks[i]  <= '0;
      end
    end else begin
      // a result loaded in S_FINISH replaces the one leaving
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_NUM_BANDS:  num_bands     <= cfg_data[NB_W-1:0];
          REG_LEDS:       leds_per_band <= cfg_data[LPB_W-1:0];
          REG_SPEED:      decay_rate    <= cfg_data[SPEED_W-1:0];
          REG_BAR_COLOR:  bar_rgb       <= cfg_data[COLOR_W-1:0];
          REG_PEAK_COLOR: peak_rgb      <= cfg_data[COLOR_W-1:0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            case (op_t'(op))
              OP_LEVEL: begin
                // bands past the array are dropped
                if (int'(band) < MAX_BANDS) begin
                  idx   <= IW'(band);
                  state <= S_LVLWR;
                end
              end
              OP_TICK: begin
                state <= S_TICK_MUL;
              end
              OP_QUERY: begin
                div_cnt <= '0;
                state   <= (lpb == '0) ? S_FINISH : S_DIV;
              end
              OP_CLEAR: begin
                for (int i = 0; i < MAX_BANDS; i++) begin
                  peaks[i] <= '0;
                end
                last_decay_time <= now_us;
              end
              default: ;
            endcase
          end
        end

        S_LVLWR: begin
          levels[idx] <= lvl;
          if (lvl > pk_rd) begin
            peaks[idx] <= lvl;
          end
          state <= S_IDLE;
        end

        S_TICK_MUL: begin
          state <= S_TICK_CMP;
        end

        S_TICK_CMP: begin
          if (decay_fire) begin
            last_decay_time <= now_hold;
            if (nb != '0) begin
              idx   <= '0;
              state <= S_DECAY;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            state <= S_IDLE;
          end
        end

        S_DECAY: begin
          if (pk_rd != '0) begin
            peaks[idx] <= pk_rd - LEVEL_W'(1);
          end
          if (int'(idx) + 1 >= int'(nb)) begin
            state <= S_IDLE;
          end else begin
            idx <= idx + IW'(1);
          end
        end

        S_DIV: begin
          div_cnt <= div_cnt + DCW'(1);
          if (int'(div_cnt) == DIV_STEPS - 1) begin
            // quotient is the band; past the bands in use stays black
            if (int'(quo_next) < int'(nb)) begin
              idx   <= IW'(quo_next);
              state <= S_MUL_LV;
            end else begin
              state <= S_FINISH;
            end
          end
        end

        S_MUL_LV:  state <= S_MUL_PK;
        S_MUL_PK:  state <= S_MUL_POS;
        S_MUL_POS: state <= S_DECIDE;
        S_DECIDE:  state <= S_FINISH;

        S_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // --- datapath registers ---
  always_ff @(posedge clk) begin
    prod <= PW'(mul_a) * PW'(mul_b);

    if (accept) begin
      lvl        <= lvl_sat;
      elapsed    <= now_us - last_decay_time;
      now_hold   <= now_us;
      pix        <= pixel;
      rem        <= '0;
      quo        <= pixel;
      color_hold <= '0;
    end

    if (state == S_DIV) begin
      rem <= rem_next;
      quo <= quo_next;
    end

    if (state == S_MUL_PK) begin
      lv_prod <= prod;
    end

    if (state == S_MUL_POS) begin
      pk_prod <= prod;
    end

    if (state == S_DECIDE) begin
      // peak marker wins over the bar
      if (peak_hit) begin
        color_hold <= peak_rgb;
      end else if (bar_hit) begin
        color_hold <= bar_rgb;
      end else begin
        color_hold <= '0;
      end
    end

    if (state == S_FINISH && out_free) begin
      color     <= color_hold;
      pixel_out <= pix;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/spbar_chk.sv =====
// ----------------------------------------------------------------------------
// spbar_chk - port-level checks for the spectrum bar renderer
// Watches handshakes and result ordering; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spbar_chk (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [spbar_pkg::OP_W-1:0]          op,
  input  logic [spbar_pkg::PIXEL_W-1:0]       pixel,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [spbar_pkg::COLOR_W-1:0]       color,
  input  logic [spbar_pkg::PIXEL_W-1:0]       pixel_out
);
  import spbar_pkg::*;

  logic [PIXEL_W-1:0] last_pix;

  // pixel of the most recent query word
  always_ff @(posedge clk) begin
    if (rst) begin
      last_pix <= '0;
    end else if (in_valid && in_ready && op == OP_QUERY) begin
      last_pix <= pixel;
    end
  end

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(color) && $stable(pixel_out))
    else $error("result word changed while stalled");

  // only queries produce results
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && op != OP_QUERY && !out_valid |=> !out_valid)
    else $error("result word without a query");

  // a query keeps the block busy right after it is taken
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && op == OP_QUERY |=> !in_ready)
    else $error("input taken right after a query");

  // a fresh result carries the pixel of the last query
  a_pixel_match: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> pixel_out == last_pix)
    else $error("result pixel does not match query");

endmodule

bind spectrum_bar_peak_hold_render_core spbar_chk u_spbar_chk (.*);

`default_nettype wire
